### rtl/necir_pkg.sv
// Shared constants, codes and types of the NEC infrared frame decoder.
`default_nettype none
package necir_pkg;

  localparam int DURATION_WIDTH = 15;
  localparam int CODE_BITS      = 32;
  localparam int FULL_PAIRS     = 34;
  localparam int CNT_W          = 6;
  localparam int IN_DATA_W      = ((2 * DURATION_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W     = 48;

  // Pulse windows in microseconds
  localparam int LEAD_MARK_MIN   = 8000;
  localparam int LEAD_MARK_MAX   = 10000;
  localparam int LEAD_SPACE_MIN  = 4000;
  localparam int LEAD_SPACE_MAX  = 5000;
  localparam int RPT_SPACE_MIN   = 2000;
  localparam int RPT_SPACE_MAX   = 2500;
  localparam int BIT_MARK_MIN    = 400;
  localparam int BIT_MARK_MAX    = 700;
  localparam int ONE_SPACE_LO    = 1500;
  localparam int ONE_SPACE_HI    = 1800;
  localparam int ZERO_SPACE_LO   = 400;
  localparam int ZERO_SPACE_HI   = 700;

  typedef logic [DURATION_WIDTH-1:0] dur_t;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_FULL    = 2'd1,
    ST_REPEAT  = 2'd2
  } status_t;

  // Window checks on one mark/space pair
  typedef struct packed {
    logic lead_mark;
    logic lead_space;
    logic rpt_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
  } pair_flags_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] code_word;
    logic [7:0]  address;
    logic [7:0]  command;
  } frame_res_t;

endpackage : necir_pkg
`default_nettype wire

### rtl/necir_classify.sv
// Range checks of one mark/space pair against the NEC pulse windows.
`default_nettype none
module necir_classify
  import necir_pkg::*;
(
  input  dur_t        mark_duration,
  input  dur_t        space_duration,
  output pair_flags_t flags
);

  always_comb begin
    flags.lead_mark  = (mark_duration >= dur_t'(LEAD_MARK_MIN)) &&
                       (mark_duration <= dur_t'(LEAD_MARK_MAX));
    flags.lead_space = (space_duration >= dur_t'(LEAD_SPACE_MIN)) &&
                       (space_duration <= dur_t'(LEAD_SPACE_MAX));
    flags.rpt_space  = (space_duration >= dur_t'(RPT_SPACE_MIN)) &&
                       (space_duration <= dur_t'(RPT_SPACE_MAX));
    flags.bit_mark   = (mark_duration >= dur_t'(BIT_MARK_MIN)) &&
                       (mark_duration <= dur_t'(BIT_MARK_MAX));
    // strict bounds on bit spaces
    flags.one_space  = (space_duration > dur_t'(ONE_SPACE_LO)) &&
                       (space_duration < dur_t'(ONE_SPACE_HI));
    flags.zero_space = (space_duration > dur_t'(ZERO_SPACE_LO)) &&
                       (space_duration < dur_t'(ZERO_SPACE_HI));
  end

endmodule : necir_classify
`default_nettype wire

### rtl/necir_frame.sv
// Frame state of the NEC decoder: pair and bit counting, code shift, verdict.
`default_nettype none
module necir_frame
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        frame_end,
  input  pair_flags_t flags,
  output frame_res_t  res
);

  logic [CNT_W-1:0] pair_count_r, pair_count_nxt;
  logic [CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [31:0]      shift_code_r, shift_code_nxt;
  logic             header_good_r, header_good_nxt;
  logic             rejected_r, rejected_nxt;
  logic             rpt_head_r, rpt_head_nxt;
  logic             rpt_trail_r, rpt_trail_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       cmd_r, cmd_nxt;

  logic first_pair;
  logic take_bit;
  logic full_ok;
  logic rpt_ok;

  always_comb begin
    first_pair      = (pair_count_r == '0);
    pair_count_nxt  = pair_count_r;
    bit_count_nxt   = bit_count_r;
    shift_code_nxt  = shift_code_r;
    header_good_nxt = header_good_r;
    rejected_nxt    = rejected_r;
    rpt_head_nxt    = rpt_head_r;
    rpt_trail_nxt   = rpt_trail_r;
    addr_nxt        = addr_r;
    cmd_nxt         = cmd_r;
    take_bit        = !first_pair && header_good_r && !rejected_r &&
                      (bit_count_r < CNT_W'(CODE_BITS)) && flags.bit_mark;

    if (first_pair) begin
      header_good_nxt = flags.lead_mark && flags.lead_space;
      rpt_head_nxt    = flags.lead_mark && flags.rpt_space;
    end else begin
      if (pair_count_r == CNT_W'(1)) begin
        rpt_trail_nxt = flags.bit_mark;
      end
      if (take_bit) begin
        if (flags.one_space) begin
          shift_code_nxt = {shift_code_r[30:0], 1'b1};
          bit_count_nxt  = bit_count_r + CNT_W'(1);
        end else if (flags.zero_space) begin
          shift_code_nxt = {shift_code_r[30:0], 1'b0};
          bit_count_nxt  = bit_count_r + CNT_W'(1);
        end else begin
          rejected_nxt = 1'b1;
        end
      end
    end
    if (pair_count_r < CNT_W'(FULL_PAIRS)) begin
      pair_count_nxt = pair_count_r + CNT_W'(1);
    end

    // verdict on the updated frame state
    full_ok = (pair_count_nxt >= CNT_W'(FULL_PAIRS)) && header_good_nxt &&
              !rejected_nxt && (bit_count_nxt == CNT_W'(CODE_BITS));
    rpt_ok  = (pair_count_nxt >= CNT_W'(2)) && rpt_head_nxt && rpt_trail_nxt;

    res.status    = ST_INVALID;
    res.code_word = '0;
    res.address   = '0;
    res.command   = '0;
    if (full_ok) begin
      res.status    = ST_FULL;
      res.code_word = shift_code_nxt;
      res.address   = shift_code_nxt[31:24];
      res.command   = shift_code_nxt[15:8];
    end else if (rpt_ok) begin
      res.status  = ST_REPEAT;
      res.address = addr_r;
      res.command = cmd_r;
    end

    if (frame_end) begin
      if (full_ok) begin
        addr_nxt = shift_code_nxt[31:24];
        cmd_nxt  = shift_code_nxt[15:8];
      end
      pair_count_nxt  = '0;
      bit_count_nxt   = '0;
      shift_code_nxt  = '0;
      header_good_nxt = 1'b0;
      rejected_nxt    = 1'b0;
      rpt_head_nxt    = 1'b0;
      rpt_trail_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r  <= '0;
      bit_count_r   <= '0;
      shift_code_r  <= '0;
      header_good_r <= 1'b0;
      rejected_r    <= 1'b0;
      rpt_head_r    <= 1'b0;
      rpt_trail_r   <= 1'b0;
      addr_r        <= '0;
      cmd_r         <= '0;
    end else if (fire) begin
      pair_count_r  <= pair_count_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_code_r  <= shift_code_nxt;
      header_good_r <= header_good_nxt;
      rejected_r    <= rejected_nxt;
      rpt_head_r    <= rpt_head_nxt;
      rpt_trail_r   <= rpt_trail_nxt;
      addr_r        <= addr_nxt;
      cmd_r         <= cmd_nxt;
    end
  end

  a_bits_max: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= CNT_W'(CODE_BITS))
    else $error("bit count beyond code length");

  a_pairs_max: assert property (@(posedge clk) disable iff (!rst_n)
    pair_count_r <= CNT_W'(FULL_PAIRS))
    else $error("pair count beyond saturation");

  a_bits_need_header: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_count_r != '0 || rejected_r) |-> header_good_r)
    else $error("bits collected without a good leader");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && frame_end) |=> (pair_count_r == '0 && bit_count_r == '0))
    else $error("frame state not cleared after last pair");

endmodule : necir_frame
`default_nettype wire

### rtl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder: input stage, decode, result register.
//
//   channel  | dir | tdata (low bit up)                       | tuser   | tlast
//   in_      | in  | mark_duration, space_duration, zero pad  | -       | frame_end
//   out_     | out | code_word, address, command              | status  | -
//
// One pair per cycle sustained while no last pair waits on a stalled result. A pair
// is registered on acceptance and decoded from that input register by range compares
// and a one-bit shift into the frame state; a pair with tlast set loads the result
// register as it is decoded, which is later only while an earlier result still waits.
// rst_n (synchronous) empties both stages, clears the frame state and the stored
// address and command. A stalled result holds only a following last pair; other
// pairs keep flowing past it.
`default_nettype none
module nec_ir_frame_decoder
  import necir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // mark_duration, space_duration, pad
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // code_word, address, command
  output logic [1:0]            out_tuser   // status
);

  // input stage
  logic        s1_valid_r;
  dur_t        s1_mark_r;
  dur_t        s1_space_r;
  logic        s1_last_r;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]  out_user_r;

  logic        out_free;
  logic        s1_adv;
  logic        s1_fire;
  pair_flags_t flags;
  frame_res_t  res;

  // advance the decode stage unless a last pair would overwrite a waiting result
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = !s1_last_r || out_free;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mark_r  <= in_tdata[DURATION_WIDTH-1:0];
      s1_space_r <= in_tdata[2*DURATION_WIDTH-1:DURATION_WIDTH];
      s1_last_r  <= in_tlast;
    end
  end

  necir_classify u_classify (
    .mark_duration  (s1_mark_r),
    .space_duration (s1_space_r),
    .flags          (flags)
  );

  necir_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .frame_end (s1_last_r),
    .flags     (flags),
    .res       (res)
  );

  // result register: load on a decoded last pair, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r <= {res.command, res.address, res.code_word};
      out_user_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_user_r == ST_INVALID || out_user_r == ST_FULL ||
                     out_user_r == ST_REPEAT))
    else $error("result carries an unused status code");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r != ST_FULL) |-> (out_data_r[31:0] == '0))
    else $error("code word set on a non-full result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_data_r))
    else $error("waiting result lost or overwritten");

endmodule : nec_ir_frame_decoder
`default_nettype wire
